/* sv/idxl_pkg.sv */
// Shared types, codes and helpers for the indexed ordered list.
`default_nettype none
package idxl_pkg;

  typedef enum logic [3:0] {
    OP_INS_FRONT  = 4'd0,
    OP_INS_BACK   = 4'd1,
    OP_REM_FRONT  = 4'd2,
    OP_REM_BACK   = 4'd3,
    OP_INS_AT     = 4'd4,
    OP_REM_AT     = 4'd5,
    OP_PEEK_AT    = 4'd6,
    OP_PEEK_FRONT = 4'd7,
    OP_PEEK_BACK  = 4'd8
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef struct packed {
    logic [3:0]  opcode;
    logic [6:0]  position;
    logic [31:0] payload;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_word;
    logic [1:0]  status;
    logic [6:0]  entry_count;
  } out_item_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic adv;  // read-out pipeline advances
    logic ins;  // open a gap at the position and load the new word
    logic rem;  // close the gap at the position
    logic rd;   // capture the word at the position for read-out
  } cell_cmd_t;

  typedef struct packed {
    logic [1:0] status;
    logic [6:0] entry_count;
  } meta_t;

  // Levels of the radix-8 read-out tree for n leaves.
  function automatic int tree_levels(input int n);
    int lg;
    lg = $clog2(n);
    return (lg + 2) / 3;
  endfunction

endpackage
`default_nettype wire

/* sv/idxl_cell.sv */
// One list entry: holds a word, shifts with its neighbours and taps it out.
`default_nettype none
module idxl_cell #(
  parameter int IDX = 0,
  parameter int W   = 32,
  parameter int PW  = 7
) (
  input  wire                       clk,
  input  wire idxl_pkg::cell_cmd_t  cmd,
  input  wire  [PW-1:0]             pos,
  input  wire  [W-1:0]              pay_word,
  input  wire  [W-1:0]              left_word,
  input  wire  [W-1:0]              right_word,
  output logic [W-1:0]              word,
  output logic [W-1:0]              tap
);

  localparam logic [PW-1:0] IdxC = PW'(IDX);

  logic [W-1:0] word_r, word_nxt;
  logic [W-1:0] tap_r, tap_nxt;

  always_comb begin
    word_nxt = word_r;
    tap_nxt  = '0;
    if (cmd.ins) begin
      if (IdxC == pos) begin
        word_nxt = pay_word;
      end else if (IdxC > pos) begin
        word_nxt = left_word;
      end
    end else if (cmd.rem && (IdxC >= pos)) begin
      word_nxt = right_word;
    end
    // take the old word, before any shift of this cycle
    if (cmd.rd && (IdxC == pos)) begin
      tap_nxt = word_r;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    if (cmd.adv) begin
      tap_r <= tap_nxt;
    end
  end

  assign word = word_r;
  assign tap  = tap_r;

endmodule
`default_nettype wire

/* sv/idxl_or_tree.sv */
// Registered radix-8 OR tree that gathers the one tapped word of the chain.
`default_nettype none
module idxl_or_tree #(
  parameter int N = 64,
  parameter int W = 32
) (
  input  wire          clk,
  input  wire          en,
  input  wire  [W-1:0] leaf [N],
  output logic [W-1:0] root
);

  localparam int Levels = idxl_pkg::tree_levels(N);

  logic [W-1:0] node_r [Levels][N];

  for (genvar l = 0; l < Levels; l++) begin : g_lvl
    localparam int SrcCnt = (N + (1 << (3 * l)) - 1) >> (3 * l);
    localparam int DstCnt = (N + (1 << (3 * (l + 1))) - 1) >> (3 * (l + 1));
    for (genvar j = 0; j < N; j++) begin : g_node
      logic [W-1:0] node_nxt;
      always_comb begin
        node_nxt = '0;
        if (j < DstCnt) begin
          for (int k = 0; k < 8; k++) begin
            if (8 * j + k < SrcCnt) begin
              if (l == 0) begin
                node_nxt = node_nxt | leaf[8 * j + k];
              end else begin
                node_nxt = node_nxt | node_r[(l == 0) ? 0 : l - 1][8 * j + k];
              end
            end
          end
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          node_r[l][j] <= node_nxt;
        end
      end
    end
  end

  assign root = node_r[Levels-1][0];

endmodule
`default_nettype wire

/* sv/indexed_ordered_list_core.sv */
// Indexed ordered list: a chain of entry cells with a registered read-out tree.
// Read-out: a result is registered in the cell taps, then in each level of the
// registered read-out OR tree, whose depth sets the latency.
// Rate: one item per cycle unless out_ready stalls; cells shift in parallel.
// Reset: entry count and pipeline valid bits clear; stored words are not
// cleared and no clearing pass runs, so items are taken from the first cycle.
`default_nettype none
module indexed_ordered_list_core #(
  parameter int CAPACITY   = 64,
  parameter int WORD_WIDTH = 32
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire idxl_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire                      out_ready,
  output idxl_pkg::out_item_t      out_data
);

  localparam int CW     = $clog2(CAPACITY + 1);
  localparam int PW     = (CW > 7) ? CW : 7;
  localparam int Levels = idxl_pkg::tree_levels(CAPACITY);

  logic [CW-1:0] count_r, count_nxt;
  logic [PW-1:0] pos_in, count_ext, p;
  logic          is_ins, is_rd, is_take, full;
  idxl_pkg::status_t st;
  logic          ins_ok, rem_ok, rd_ok, acc, en;
  idxl_pkg::cell_cmd_t cmd;
  logic [WORD_WIDTH-1:0] pay_word;
  logic [WORD_WIDTH-1:0] word [CAPACITY];
  logic [WORD_WIDTH-1:0] tap  [CAPACITY];
  logic [WORD_WIDTH-1:0] tree_word;

  logic               v_r    [Levels+1];
  idxl_pkg::meta_t    meta_r [Levels+1];

  assign pos_in    = PW'(in_data.position);
  assign count_ext = PW'(count_r);
  assign full      = (count_r == CW'(CAPACITY));
  assign pay_word  = WORD_WIDTH'(64'(in_data.payload));

  always_comb begin
    is_ins  = 1'b0;
    is_rd   = 1'b0;
    is_take = 1'b0;
    p       = pos_in;
    case (in_data.opcode)
      idxl_pkg::OP_INS_FRONT: begin
        is_ins = 1'b1;
        p      = '0;
      end
      idxl_pkg::OP_INS_BACK: begin
        is_ins = 1'b1;
        p      = count_ext;
      end
      idxl_pkg::OP_INS_AT: begin
        is_ins = 1'b1;
      end
      idxl_pkg::OP_REM_FRONT: begin
        is_rd   = 1'b1;
        is_take = 1'b1;
        p       = '0;
      end
      idxl_pkg::OP_REM_BACK: begin
        is_rd   = 1'b1;
        is_take = 1'b1;
        p       = count_ext - 1'b1;
      end
      idxl_pkg::OP_REM_AT: begin
        is_rd   = 1'b1;
        is_take = 1'b1;
      end
      idxl_pkg::OP_PEEK_AT: begin
        is_rd = 1'b1;
      end
      idxl_pkg::OP_PEEK_FRONT: begin
        is_rd = 1'b1;
        p     = '0;
      end
      idxl_pkg::OP_PEEK_BACK: begin
        is_rd = 1'b1;
        p     = count_ext - 1'b1;
      end
      default: begin
        is_ins = 1'b0;
      end
    endcase
  end

  always_comb begin
    st = idxl_pkg::ST_OK;
    if (is_ins) begin
      if (full) begin
        st = idxl_pkg::ST_FULL;
      end else if (p > count_ext) begin
        st = idxl_pkg::ST_RANGE;
      end
    end else if (is_rd) begin
      if (count_r == '0) begin
        st = idxl_pkg::ST_EMPTY;
      end else if (p >= count_ext) begin
        st = idxl_pkg::ST_RANGE;
      end
    end
  end

  assign en       = !v_r[Levels] || out_ready;
  assign in_ready = en;
  assign acc      = in_valid && en;
  assign ins_ok   = is_ins && (st == idxl_pkg::ST_OK);
  assign rd_ok    = is_rd && (st == idxl_pkg::ST_OK);
  assign rem_ok   = rd_ok && is_take;

  assign cmd.adv = en;
  assign cmd.ins = acc && ins_ok;
  assign cmd.rem = acc && rem_ok;
  assign cmd.rd  = acc && rd_ok;

  always_comb begin
    count_nxt = count_r;
    if (cmd.ins) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.rem) begin
      count_nxt = count_r - 1'b1;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [WORD_WIDTH-1:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = word[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = word[i+1];
    end
    idxl_cell #(
      .IDX (i),
      .W   (WORD_WIDTH),
      .PW  (PW)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .pos        (p),
      .pay_word   (pay_word),
      .left_word  (left_w),
      .right_word (right_w),
      .word       (word[i]),
      .tap        (tap[i])
    );
  end

  idxl_or_tree #(
    .N (CAPACITY),
    .W (WORD_WIDTH)
  ) u_tree (
    .clk  (clk),
    .en   (en),
    .leaf (tap),
    .root (tree_word)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      for (int l = 0; l <= Levels; l++) begin
        v_r[l] <= 1'b0;
      end
    end else begin
      if (acc) begin
        count_r <= count_nxt;
      end
      if (en) begin
        v_r[0] <= in_valid;
        for (int l = 1; l <= Levels; l++) begin
          v_r[l] <= v_r[l-1];
        end
      end
    end
  end

  // status and count travel alongside the tree levels
  always_ff @(posedge clk) begin
    if (en) begin
      meta_r[0].status      <= st;
      meta_r[0].entry_count <= 7'(count_nxt);
      for (int l = 1; l <= Levels; l++) begin
        meta_r[l] <= meta_r[l-1];
      end
    end
  end

  assign out_valid            = v_r[Levels];
  assign out_data.read_word   = 32'(64'(tree_word));
  assign out_data.status      = meta_r[Levels].status;
  assign out_data.entry_count = meta_r[Levels].entry_count;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && ins_ok) |=> (count_r == $past(count_r) + 1'b1))
    else $error("successful insert did not raise the count");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == idxl_pkg::ST_FULL)) |->
      (out_data.entry_count == 7'(CAPACITY)))
    else $error("full status with count below capacity");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == idxl_pkg::ST_EMPTY)) |->
      (out_data.entry_count == '0))
    else $error("empty status with non-zero count");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status != idxl_pkg::ST_OK)) |->
      (out_data.read_word == '0))
    else $error("failed command returned a non-zero word");
`endif

endmodule
`default_nettype wire
